/* rtl/kcn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcn_pkg: shared types and constants for the RGB kernel normalizer
// Word layouts of the command and result ports, field widths, function
// and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package kcn_pkg;

    // Field widths
    localparam int SAMPLE_W = 24;   // signed Q7.16 input sample
    localparam int ELEM_W   = 23;   // unsigned Q7.16 stored element
    localparam int FRAC_W   = 16;   // fraction bits of the Q1.16 quotient
    localparam int QUO_W    = FRAC_W + 1;  // quotient reaches 1.0 = 2^16
    localparam int STATUS_W = 2;
    localparam int NCH      = 3;    // red, green, blue
    localparam int BIT_W    = $clog2(QUO_W);

    // Function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_NORM  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RAW   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Command word
    typedef struct packed {
        logic                       func;
        logic signed [SAMPLE_W-1:0] red_in;
        logic signed [SAMPLE_W-1:0] green_in;
        logic signed [SAMPLE_W-1:0] blue_in;
        logic                       last_in;
    } t_in;

    // Result word
    typedef struct packed {
        logic [ELEM_W-1:0]   red_out;
        logic [ELEM_W-1:0]   green_out;
        logic [ELEM_W-1:0]   blue_out;
        logic [STATUS_W-1:0] status;
        logic                last_out;
    } t_out;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_DIV
    } t_state;

endpackage

`default_nettype wire

/* rtl/kernel_clamp_normalize_rgb_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kernel_clamp_normalize_rgb_top: nonnegative, sum-to-one RGB kernel normalizer
// Stores clamped kernel elements and normalizes them on readout with a
// bit-serial restoring divider per channel.
// ----------------------------------------------------------------------------
// Usage:
//   A command word on i_item is taken at a rising edge with start high and
//   busy low. A load (func 0) clamps the three samples, writes them to the
//   element RAM and adds them to the channel sums in that same edge; it
//   gives no result and leaves busy low, so loads go one per cycle while
//   no read is busy; last_in closes the kernel, a later load starts a new one.
//   A read (func 1) returns one result word on o_res, marked by o_res_vld
//   for exactly one cycle; the receiver cannot stall it.
//   Read with nothing pending: result in the next cycle, status 2, busy low.
//   Read while some channel sum is zero: RAM fetch, then raw result, status 1.
//   Normalized read: RAM fetch, then the serial divider, one quotient bit
//   per cycle; busy stays high through fetch and divide, and the result
//   appears in the cycle busy drops, when the next read can go in.
//   The divider's one-bit-per-cycle loop sets the read rate.
//   Reset (synchronous, active low) clears sums, count, pointer and phase;
//   the element RAM needs no clearing since only written entries are read.
// ----------------------------------------------------------------------------
module kernel_clamp_normalize_rgb_top #(
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int SW    = kcn_pkg::ELEM_W + CW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire kcn_pkg::t_in  i_item,
    output logic               o_res_vld,
    output kcn_pkg::t_out      o_res
);

    import kcn_pkg::*;

    localparam logic [BIT_W-1:0] DIV_LAST = BIT_W'(QUO_W - 1);

    // Clamp a signed sample to an unsigned element
    function automatic logic [ELEM_W-1:0] clamp_sample(input logic [SAMPLE_W-1:0] x);
        logic [ELEM_W-1:0] v;
        v = x[SAMPLE_W-1] ? '0 : x[ELEM_W-1:0];
        return v;
    endfunction

    // Control state
    t_state            r_state, n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_ptr;
    logic              r_phase;
    logic [SW-1:0]     r_sum [NCH];
    logic [BIT_W-1:0]  r_bit;
    logic              r_res_vld;

    // Datapath registers
    logic [SW-1:0]     r_rem [NCH];
    logic [QUO_W-1:0]  r_dvd [NCH];
    logic [QUO_W-1:0]  r_quo [NCH];
    logic              r_last;
    t_out              r_res;

    // Combinational signals
    logic              w_acc, w_load, w_read, w_rd_ok;
    logic              w_fetch, w_div;
    logic [CW-1:0]     w_base;
    logic              w_room;
    logic [ELEM_W-1:0] w_elem [NCH];
    logic [ELEM_W-1:0] w_rd [NCH];
    logic [SW-1:0]     w_base_sum [NCH];
    logic [SW:0]       w_trial [NCH];
    logic [SW:0]       w_diff [NCH];
    logic              w_ge [NCH];
    logic [QUO_W-1:0]  w_quo [NCH];
    logic              w_zero;
    logic [NCH*ELEM_W-1:0] w_wdata, w_rdata;

    // Handshake decode
    assign w_acc   = start && !busy;
    assign w_load  = w_acc && (i_item.func == FUNC_LOAD);
    assign w_read  = w_acc && (i_item.func == FUNC_READ);
    assign w_rd_ok = r_phase && (r_ptr < r_count);

    // Load addressing: a load after the kernel closed restarts at zero
    assign w_base = r_phase ? '0 : r_count;
    assign w_room = w_base < CW'(DEPTH);

    // Clamp samples, split RAM words, run one divider step per channel
    always_comb begin
        w_elem[0] = clamp_sample(i_item.red_in);
        w_elem[1] = clamp_sample(i_item.green_in);
        w_elem[2] = clamp_sample(i_item.blue_in);
        for (int c = 0; c < NCH; c++) begin
            w_rd[c]       = w_rdata[c*ELEM_W +: ELEM_W];
            w_base_sum[c] = r_phase ? '0 : r_sum[c];
            w_trial[c]    = {r_rem[c], r_dvd[c][QUO_W-1]};
            w_diff[c]     = w_trial[c] - {1'b0, r_sum[c]};
            w_ge[c]       = (w_trial[c] >= {1'b0, r_sum[c]});
            w_quo[c]      = {r_quo[c][QUO_W-2:0], w_ge[c]};
        end
    end

    assign w_wdata = {w_elem[2], w_elem[1], w_elem[0]};
    assign w_zero  = (r_sum[0] == '0) || (r_sum[1] == '0) || (r_sum[2] == '0);

    // Element store: red in the low slice, blue in the high slice
    kcn_ram #(
        .WIDTH (NCH * ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_load && w_room),
        .i_waddr (w_base[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_read && w_rd_ok),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_read && w_rd_ok) n_state = S_FETCH;
            end
            S_FETCH: begin
                n_state = w_zero ? S_IDLE : S_DIV;
            end
            S_DIV: begin
                if (r_bit == DIV_LAST) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        busy    = 1'b1;
        w_fetch = 1'b0;
        w_div   = 1'b0;
        unique case (r_state)
            S_IDLE:  busy    = 1'b0;
            S_FETCH: w_fetch = 1'b1;
            S_DIV:   w_div   = 1'b1;
            default: busy    = 1'b1;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ptr     <= '0;
            r_phase   <= 1'b0;
            r_bit     <= '0;
            r_res_vld <= 1'b0;
            for (int c = 0; c < NCH; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_res_vld <= 1'b0;
            // Accumulate a load; drop samples past the store depth
            if (w_load) begin
                if (w_room) begin
                    r_count <= CW'(w_base + 1'b1);
                    for (int c = 0; c < NCH; c++) begin
                        r_sum[c] <= w_base_sum[c] + SW'(w_elem[c]);
                    end
                end
                r_ptr   <= '0;
                r_phase <= i_item.last_in;
            end
            // Advance the read pointer, or flag an empty read
            if (w_read) begin
                if (w_rd_ok) begin
                    r_ptr <= CW'(r_ptr + 1'b1);
                end else begin
                    r_res_vld <= 1'b1;
                end
            end
            // Raw result goes out right after the fetch
            if (w_fetch) begin
                r_bit <= '0;
                if (w_zero) r_res_vld <= 1'b1;
            end
            if (w_div) begin
                r_bit <= BIT_W'(r_bit + 1'b1);
                if (r_bit == DIV_LAST) r_res_vld <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_read) begin
            if (w_rd_ok) begin
                r_last <= (CW'(r_ptr + 1'b1) == r_count);
            end else begin
                r_res.red_out   <= '0;
                r_res.green_out <= '0;
                r_res.blue_out  <= '0;
                r_res.status    <= ST_EMPTY;
                r_res.last_out  <= 1'b0;
            end
        end
        if (w_fetch) begin
            if (w_zero) begin
                r_res.red_out   <= w_rd[0];
                r_res.green_out <= w_rd[1];
                r_res.blue_out  <= w_rd[2];
                r_res.status    <= ST_RAW;
                r_res.last_out  <= r_last;
            end
            // Seed the divider: element <= sum, so the top bits sit below sum
            for (int c = 0; c < NCH; c++) begin
                r_rem[c] <= SW'(w_rd[c][ELEM_W-1:1]);
                r_dvd[c] <= {w_rd[c][0], {FRAC_W{1'b0}}};
                r_quo[c] <= '0;
            end
        end
        // One restoring step per cycle, one quotient bit per channel
        if (w_div) begin
            for (int c = 0; c < NCH; c++) begin
                r_rem[c] <= w_ge[c] ? w_diff[c][SW-1:0] : w_trial[c][SW-1:0];
                r_dvd[c] <= {r_dvd[c][QUO_W-2:0], 1'b0};
                r_quo[c] <= w_quo[c];
            end
            if (r_bit == DIV_LAST) begin
                r_res.red_out   <= ELEM_W'(w_quo[0]);
                r_res.green_out <= ELEM_W'(w_quo[1]);
                r_res.blue_out  <= ELEM_W'(w_quo[2]);
                r_res.status    <= ST_NORM;
                r_res.last_out  <= r_last;
            end
        end
    end

    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Read pointer never passes the element count
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= r_count)
        else $error("read pointer beyond element count");

    // Final divider step is followed by a result word
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_bit == DIV_LAST) |=> (o_res_vld && o_res.status == ST_NORM))
        else $error("divider finished without a result");

    // A normalized element never exceeds 1.0
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && o_res.status == ST_NORM) |->
            (o_res.red_out <= ELEM_W'(1 << FRAC_W) &&
             o_res.green_out <= ELEM_W'(1 << FRAC_W) &&
             o_res.blue_out <= ELEM_W'(1 << FRAC_W)))
        else $error("normalized element above one");

    // An accepted read with nothing pending answers at once with status 2
    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_read && !w_rd_ok) |=> (o_res_vld && o_res.status == ST_EMPTY))
        else $error("empty read not reported");

endmodule

`default_nettype wire

/* rtl/kcn_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcn_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are undefined
// until written.
// ----------------------------------------------------------------------------
module kcn_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
